@@ design/bmrf_pkg.sv @@
package bmrf_pkg;

  localparam int DEF_FIFO_DEPTH   = 16;
  localparam int DEF_READER_SLOTS = 4;
  localparam int DEF_WORD_BITS    = 32;

  localparam int KIND_BITS   = 2;
  localparam int READER_BITS = 2;
  localparam int STATUS_BITS = 3;

  typedef logic [KIND_BITS-1:0]   kind_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam kind_t KIND_PUSH  = 2'd0;
  localparam kind_t KIND_POP   = 2'd1;
  localparam kind_t KIND_SUB   = 2'd2;
  localparam kind_t KIND_UNSUB = 2'd3;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_EMPTY   = 3'd1;
  localparam status_t ST_FULL    = 3'd2;
  localparam status_t ST_DROPPED = 3'd3;
  localparam status_t ST_NOT_SUB = 3'd4;
  localparam status_t ST_ALREADY = 3'd5;

  typedef struct packed {
    kind_t                  kind;
    logic [READER_BITS-1:0] reader;
    logic                   reader_ok;
  } cmd_t;

  localparam int CMD_BITS = $bits(cmd_t);

endpackage

@@ design/broadcast_multi_reader_fifo.sv @@
// channel  dir  tdata (low bit up)                          tuser
// in_      in   reader[1:0], push_word[WORD_BITS], zero pad  kind[1:0]
// out_     out  status[2:0], read_word[WORD_BITS],           -
//               unread_left[clog2(FIFO_DEPTH+1)], zero pad
// a beat passes an input register and a two-entry command queue, then the
// executing sequencer: push, subscribe, unsubscribe and refused pop go IDLE to OUT;
// a pop that reads passes RDATA for the registered ring read; OUT holds each result.
// input side accepts while a result waits, until queue and input register are full.
// reset clears pointers, counts and reader flags; ring contents are not cleared.
module broadcast_multi_reader_fifo #(
  parameter int FIFO_DEPTH   = bmrf_pkg::DEF_FIFO_DEPTH,
  parameter int READER_SLOTS = bmrf_pkg::DEF_READER_SLOTS,
  parameter int WORD_BITS    = bmrf_pkg::DEF_WORD_BITS,
  localparam int CW          = $clog2(FIFO_DEPTH + 1),
  localparam int IN_BITS     = ((bmrf_pkg::READER_BITS + WORD_BITS + 7) / 8) * 8,
  localparam int OUT_BITS    = ((bmrf_pkg::STATUS_BITS + WORD_BITS + CW + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_BITS-1:0]              in_tdata,  // reader, push_word
  input  logic [bmrf_pkg::KIND_BITS-1:0]  in_tuser,  // kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_BITS-1:0]             out_tdata  // status, read_word, unread_left
);
  import bmrf_pkg::*;

  localparam int Q_BITS  = CMD_BITS + WORD_BITS;
  localparam int PAD_OUT = OUT_BITS - STATUS_BITS - WORD_BITS - CW;

  logic                 f_valid, f_ready;
  cmd_t                 f_cmd;
  logic [WORD_BITS-1:0] f_word;
  logic [Q_BITS-1:0]    q_dout;
  logic                 b_valid, b_ready;
  cmd_t                 b_cmd;
  logic [WORD_BITS-1:0] b_word;
  status_t              r_status;
  logic [WORD_BITS-1:0] r_word;
  logic [CW-1:0]        r_unread;

  bmrf_front #(
    .READER_SLOTS (READER_SLOTS),
    .WORD_BITS    (WORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_reader (in_tdata[READER_BITS-1:0]),
    .in_word   (in_tdata[READER_BITS +: WORD_BITS]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_cmd   (f_cmd),
    .out_word  (f_word)
  );

  bmrf_cmd_queue #(
    .WIDTH (Q_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_word, f_cmd}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_dout)
  );

  assign b_cmd  = cmd_t'(q_dout[CMD_BITS-1:0]);
  assign b_word = q_dout[CMD_BITS +: WORD_BITS];

  bmrf_back #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .READER_SLOTS (READER_SLOTS),
    .WORD_BITS    (WORD_BITS),
    .CW           (CW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (b_valid),
    .cmd_ready  (b_ready),
    .cmd        (b_cmd),
    .cmd_word   (b_word),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_status (r_status),
    .res_word   (r_word),
    .res_unread (r_unread)
  );

  generate
    if (PAD_OUT > 0) begin : g_pad
      assign out_tdata = {{PAD_OUT{1'b0}}, r_unread, r_word, r_status};
    end else begin : g_nopad
      assign out_tdata = {r_unread, r_word, r_status};
    end
  endgenerate

endmodule

@@ design/bmrf_front.sv @@
module bmrf_front #(
  parameter int READER_SLOTS = 4,
  parameter int WORD_BITS    = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bmrf_pkg::kind_t                      in_kind,
  input  logic [bmrf_pkg::READER_BITS-1:0]     in_reader,
  input  logic [WORD_BITS-1:0]                 in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bmrf_pkg::cmd_t                       out_cmd,
  output logic [WORD_BITS-1:0]                 out_word
);
  import bmrf_pkg::*;

  logic                 vld_r;
  cmd_t                 cmd_r;
  logic [WORD_BITS-1:0] word_r;

  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_cmd   = cmd_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // classify the beat: slot in range or not
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r.kind      <= in_kind;
      cmd_r.reader    <= in_reader;
      cmd_r.reader_ok <= (int'(in_reader) < READER_SLOTS);
      word_r          <= in_word;
    end
  end

endmodule

@@ design/bmrf_cmd_queue.sv @@
module bmrf_cmd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic             pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ design/bmrf_back.sv @@
module bmrf_back #(
  parameter int FIFO_DEPTH   = 16,
  parameter int READER_SLOTS = 4,
  parameter int WORD_BITS    = 32,
  parameter int AW           = $clog2(FIFO_DEPTH),
  parameter int CW           = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  bmrf_pkg::cmd_t             cmd,
  input  logic [WORD_BITS-1:0]       cmd_word,
  output logic                       res_valid,
  input  logic                       res_ready,
  output bmrf_pkg::status_t          res_status,
  output logic [WORD_BITS-1:0]       res_word,
  output logic [CW-1:0]              res_unread
);
  import bmrf_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RDATA = 2'd1;
  localparam logic [1:0] S_OUT   = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [WORD_BITS-1:0]    ring_mem [FIFO_DEPTH];
  logic [WORD_BITS-1:0]    rd_data_r;
  logic [AW-1:0]           wp_r, wp_nxt;
  logic [CW-1:0]           held_r, held_nxt;
  logic [READER_SLOTS-1:0] active_r, active_nxt;
  logic [CW-1:0]           unread_r   [READER_SLOTS];
  logic [CW-1:0]           unread_nxt [READER_SLOTS];
  status_t                 status_r, status_nxt;
  logic [WORD_BITS-1:0]    word_r;
  logic [CW-1:0]           left_r, left_nxt;

  logic                    take;
  logic [READER_SLOTS-1:0] sel;
  logic                    act_sel;
  logic [CW-1:0]           unread_sel;
  logic [CW-1:0]           unread_dec;
  logic [CW-1:0]           max_other;
  logic                    any_act;
  logic [CW:0]             pos_ext;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic                    rd_en;

  assign take       = cmd_valid && (state_r == S_IDLE);
  assign cmd_ready  = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_OUT);
  assign res_status = status_r;
  assign res_word   = word_r;
  assign res_unread = left_r;
  assign any_act    = |active_r;
  assign unread_dec = unread_sel - 1'b1;

  // slot select and slowest other reader
  always_comb begin
    sel        = '0;
    act_sel    = 1'b0;
    unread_sel = '0;
    max_other  = '0;
    for (int i = 0; i < READER_SLOTS; i++) begin
      sel[i] = cmd.reader_ok && (int'(cmd.reader) == i);
      if (sel[i]) begin
        act_sel    = active_r[i];
        unread_sel = unread_r[i];
      end
      if (!sel[i] && active_r[i] && unread_r[i] > max_other) begin
        max_other = unread_r[i];
      end
    end
  end

  // read position is write point minus unread count
  always_comb begin
    pos_ext = (CW+1)'(wp_r) - (CW+1)'(unread_sel);
    if (pos_ext[CW]) begin
      pos_ext = pos_ext + (CW+1)'(FIFO_DEPTH);
    end
    rd_addr = pos_ext[AW-1:0];
  end

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    held_nxt   = held_r;
    active_nxt = active_r;
    unread_nxt = unread_r;
    status_nxt = status_r;
    left_nxt   = left_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          status_nxt = ST_OK;
          state_nxt  = S_OUT;
          unique case (cmd.kind)
            KIND_PUSH: begin
              if (!any_act) begin
                status_nxt = ST_DROPPED;
              end else if (held_r >= CW'(FIFO_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wp_nxt   = (wp_r == AW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
                held_nxt = held_r + 1'b1;
                for (int i = 0; i < READER_SLOTS; i++) begin
                  if (active_r[i] && unread_r[i] < CW'(FIFO_DEPTH)) begin
                    unread_nxt[i] = unread_r[i] + 1'b1;
                  end
                end
              end
            end
            KIND_POP: begin
              if (!act_sel) begin
                status_nxt = ST_NOT_SUB;
              end else if (unread_sel == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_RDATA;
                for (int i = 0; i < READER_SLOTS; i++) begin
                  if (sel[i]) begin
                    unread_nxt[i] = unread_dec;
                  end
                end
                if (max_other <= unread_dec && held_r != '0) begin
                  held_nxt = held_r - 1'b1;
                end
              end
            end
            KIND_SUB: begin
              if (!cmd.reader_ok) begin
                status_nxt = ST_NOT_SUB;
              end else if (act_sel) begin
                status_nxt = ST_ALREADY;
              end else begin
                for (int i = 0; i < READER_SLOTS; i++) begin
                  if (sel[i]) begin
                    active_nxt[i] = 1'b1;
                    unread_nxt[i] = (held_r == '0) ? '0 : CW'(1);
                  end
                end
              end
            end
            KIND_UNSUB: begin
              if (!act_sel) begin
                status_nxt = ST_NOT_SUB;
              end else begin
                if (max_other <= unread_sel) begin
                  held_nxt = max_other;
                end
                for (int i = 0; i < READER_SLOTS; i++) begin
                  if (sel[i]) begin
                    active_nxt[i] = 1'b0;
                    unread_nxt[i] = '0;
                  end
                end
              end
            end
          endcase
          left_nxt = '0;
          for (int i = 0; i < READER_SLOTS; i++) begin
            if (sel[i] && active_nxt[i]) begin
              left_nxt = unread_nxt[i];
            end
          end
        end
      end
      S_RDATA: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      held_r   <= '0;
      active_r <= '0;
      for (int i = 0; i < READER_SLOTS; i++) begin
        unread_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      held_r   <= held_nxt;
      active_r <= active_nxt;
      unread_r <= unread_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    left_r   <= left_nxt;
    if (take) begin
      word_r <= '0;
    end else if (state_r == S_RDATA) begin
      word_r <= rd_data_r;
    end
  end

  // ring storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wp_r] <= cmd_word;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(FIFO_DEPTH))
    else $error("held count above depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(|active_r) |-> (held_r == '0))
    else $error("words held with no reader subscribed");

  a_rdata_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDATA) |=> (state_r == S_OUT))
    else $error("pop read data not turned into a result");

  for (genvar g = 0; g < READER_SLOTS; g++) begin : g_chk
    a_unread_held: assert property (@(posedge clk) disable iff (!rst_n)
      active_r[g] |-> (unread_r[g] <= held_r))
      else $error("reader unread count beyond held words");
  end
`endif

endmodule

@@ tb/tb_broadcast_multi_reader_fifo.sv @@
`timescale 1ns / 1ps

module tb_broadcast_multi_reader_fifo;
  import bmrf_pkg::*;

  localparam int DEPTH    = DEF_FIFO_DEPTH;
  localparam int SLOTS    = DEF_READER_SLOTS;
  localparam int WBITS    = DEF_WORD_BITS;
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int IN_BITS  = ((READER_BITS + WBITS + 7) / 8) * 8;
  localparam int OUT_BITS = ((STATUS_BITS + WBITS + CW + 7) / 8) * 8;
  localparam int WORD_LSB = STATUS_BITS;
  localparam int CNT_LSB  = STATUS_BITS + WBITS;
  localparam int RANDOM_OPS = 1500;
  localparam int EXP_SLOTS  = 16;

  typedef logic [READER_BITS-1:0] slot_t;
  typedef logic [WBITS-1:0]       word_t;
  typedef logic [CW-1:0]          count_t;

  typedef struct {
    status_t status;
    word_t   read_word;
    count_t  unread_left;
  } fifo_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_BITS-1:0]  in_tdata;
  logic [KIND_BITS-1:0] in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_BITS-1:0] out_tdata;

  // predictor state
  word_t          ring_words [DEPTH];
  logic [$clog2(DEPTH)-1:0] wr_ptr;
  count_t         held_words;
  logic           subscribed [SLOTS];
  count_t         lag [SLOTS];

  fifo_result_t   expected_ring [EXP_SLOTS];
  int             exp_wr_idx;
  int             exp_rd_idx;
  int             mismatch_count;
  int             status_seen [8];
  int             ops_sent;
  bit             steady_flow;

  broadcast_multi_reader_fifo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),  // reader, push_word
    .in_tuser   (in_tuser),  // kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)  // status, read_word, unread_left
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic count_t max_lag_other(int skip);
    count_t m;
    m = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i != skip && subscribed[i] && lag[i] > m) m = lag[i];
    end
    return m;
  endfunction

  function automatic fifo_result_t predict_fifo_op(kind_t kind, slot_t rdr, word_t word);
    fifo_result_t res;
    logic         any_sub;
    logic [$clog2(DEPTH)-1:0] pos;
    count_t       others;
    res.status    = ST_OK;
    res.read_word = '0;
    any_sub = 1'b0;
    for (int i = 0; i < SLOTS; i++) any_sub |= subscribed[i];
    case (kind)
      KIND_PUSH: begin
        if (!any_sub) begin
          res.status = ST_DROPPED;
        end else if (held_words >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring_words[wr_ptr] = word;
          wr_ptr = wr_ptr + 1'b1;
          held_words = held_words + 1'b1;
          for (int i = 0; i < SLOTS; i++) begin
            if (subscribed[i] && lag[i] < DEPTH) lag[i] = lag[i] + 1'b1;
          end
        end
      end
      KIND_POP: begin
        if (!subscribed[rdr]) begin
          res.status = ST_NOT_SUB;
        end else if (lag[rdr] == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = wr_ptr - lag[rdr][$clog2(DEPTH)-1:0];
          res.read_word = ring_words[pos];
          lag[rdr] = lag[rdr] - 1'b1;
          if (max_lag_other(rdr) <= lag[rdr] && held_words > 0)
            held_words = held_words - 1'b1;
        end
      end
      KIND_SUB: begin
        if (subscribed[rdr]) begin
          res.status = ST_ALREADY;
        end else begin
          subscribed[rdr] = 1'b1;
          lag[rdr] = (held_words == 0) ? count_t'(0) : count_t'(1);
        end
      end
      default: begin
        if (!subscribed[rdr]) begin
          res.status = ST_NOT_SUB;
        end else begin
          others = max_lag_other(rdr);
          if (others <= lag[rdr]) held_words = others;
          subscribed[rdr] = 1'b0;
          lag[rdr] = '0;
        end
      end
    endcase
    res.unread_left = subscribed[rdr] ? lag[rdr] : count_t'(0);
    return res;
  endfunction

  task automatic send_op(kind_t kind, slot_t rdr, word_t word);
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < 13) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_BITS'({word, rdr});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_ring[exp_wr_idx % EXP_SLOTS] = predict_fifo_op(kind, rdr, word);
    exp_wr_idx++;
    ops_sent++;
  endtask

  always @(posedge clk) begin
    if (!steady_flow) out_tready <= ($urandom_range(0, 99) >= 13);
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    fifo_result_t exp_res;
    status_t      got_status;
    word_t        got_word;
    count_t       got_left;
    if (rst_n && out_tvalid && out_tready) begin
      got_status = out_tdata[0 +: STATUS_BITS];
      got_word   = out_tdata[WORD_LSB +: WBITS];
      got_left   = out_tdata[CNT_LSB +: CW];
      if (exp_wr_idx == exp_rd_idx) begin
        $error("result beat with no operation outstanding: status %0d", got_status);
        mismatch_count++;
      end else begin
        exp_res = expected_ring[exp_rd_idx % EXP_SLOTS];
        exp_rd_idx++;
        status_seen[got_status]++;
        if (got_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, got_status);
          mismatch_count++;
        end
        if (got_word !== exp_res.read_word) begin
          $error("read_word: expected %h, got %h", exp_res.read_word, got_word);
          mismatch_count++;
        end
        if (got_left !== exp_res.unread_left) begin
          $error("unread_left: expected %0d, got %0d", exp_res.unread_left, got_left);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_no_subscribers();
    send_op(KIND_PUSH, 2'd0, '1);
    send_op(KIND_POP, 2'd3, '0);
    send_op(KIND_UNSUB, 2'd0, '0);
  endtask

  task automatic test_subscribe_rules();
    send_op(KIND_SUB, 2'd0, '0);
    send_op(KIND_SUB, 2'd0, '0);
    send_op(KIND_POP, 2'd0, '0);
  endtask

  task automatic test_fill_to_full();
    send_op(KIND_PUSH, 2'd1, '0);
    send_op(KIND_PUSH, 2'd2, '1);
    for (int i = 2; i < DEPTH; i++) send_op(KIND_PUSH, slot_t'(i), word_t'($urandom));
    send_op(KIND_PUSH, 2'd0, 32'hA5A5_5A5A);
  endtask

  task automatic test_late_subscriber();
    send_op(KIND_SUB, 2'd3, '0);
    send_op(KIND_POP, 2'd3, '0);
    send_op(KIND_UNSUB, 2'd0, '0);
    send_op(KIND_PUSH, 2'd0, word_t'($urandom));
    send_op(KIND_POP, 2'd3, '0);
  endtask

  task automatic test_random_traffic(int count);
    int    mode;
    int    roll;
    kind_t kind;
    word_t word;
    mode = 0;
    for (int n = 0; n < count; n++) begin
      steady_flow = (n >= 500 && n < 800);
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      // fill-heavy, drain-heavy and balanced phases
      case (mode)
        0:       kind = roll < 60 ? KIND_PUSH : roll < 85 ? KIND_POP :
                        roll < 95 ? KIND_SUB : KIND_UNSUB;
        1:       kind = roll < 15 ? KIND_PUSH : roll < 90 ? KIND_POP :
                        roll < 97 ? KIND_SUB : KIND_UNSUB;
        default: kind = roll < 40 ? KIND_PUSH : roll < 80 ? KIND_POP :
                        roll < 92 ? KIND_SUB : KIND_UNSUB;
      endcase
      case ($urandom_range(0, 15))
        0:       word = '0;
        1:       word = '1;
        default: word = word_t'($urandom);
      endcase
      send_op(kind, slot_t'($urandom_range(0, SLOTS - 1)), word);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= KIND_PUSH;
    mismatch_count = 0;
    ops_sent       = 0;
    exp_wr_idx     = 0;
    exp_rd_idx     = 0;
    steady_flow    = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;
    wr_ptr     = '0;
    held_words = '0;
    for (int i = 0; i < SLOTS; i++) begin
      subscribed[i] = 1'b0;
      lag[i]        = '0;
    end
    for (int i = 0; i < DEPTH; i++) ring_words[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_subscribers();
    test_subscribe_rules();
    test_fill_to_full();
    test_late_subscriber();
    test_random_traffic(RANDOM_OPS);

    in_tvalid <= 1'b0;
    while (exp_wr_idx != exp_rd_idx) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d operations checked: ok %0d, nothing to read %0d, full %0d",
             ops_sent, status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL]);
    $display("dropped with no subscribers %0d, not subscribed %0d, already subscribed %0d",
             status_seen[ST_DROPPED], status_seen[ST_NOT_SUB], status_seen[ST_ALREADY]);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", exp_wr_idx - exp_rd_idx);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
